[rtl/icas_pkg.sv]
// Package: types, constants and codes for the interpolated CDF angle sampler.
package icas_pkg;

  localparam int MAX_ENERGIES = 32;
  localparam int MAX_ANGLES   = 64;
  localparam int COL_W        = 5;
  localparam int ROW_W        = 6;
  localparam int CDF_AW       = ROW_W + COL_W;

  localparam logic [1:0] REQ_GRID   = 2'd0;
  localparam logic [1:0] REQ_ANGLE  = 2'd1;
  localparam logic [1:0] REQ_CDF    = 2'd2;
  localparam logic [1:0] REQ_SAMPLE = 2'd3;

  localparam logic [1:0] CLAMP_NONE  = 2'd0;
  localparam logic [1:0] CLAMP_BELOW = 2'd1;
  localparam logic [1:0] CLAMP_ABOVE = 2'd2;

  localparam logic [1:0] CFG_ENERGIES = 2'd0;
  localparam logic [1:0] CFG_ANGLES   = 2'd1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         row_index;
    logic [4:0]         column_index;
    logic signed [23:0] grid_value;
    logic [16:0]        table_value;
    logic signed [23:0] log_energy;
    logic [15:0]        random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [15:0] angle_code;
    logic [5:0]  chosen_row;
    logic [1:0]  energy_clamp;
    logic        fell_through;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch sample, start grid scan
    logic grid_step;   // examine one grid pair
    logic div_start;
    logic div_step;
    logic row_clear;
    logic row_issue;   // read cdf entries for current row
    logic row_eval;    // compare blended value
    logic fin;         // form result
  } icas_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic grid_done;
    logic need_div;
    logic div_done;
    logic row_hit;
    logic row_last;
  } icas_sts_t;

endpackage

[rtl/icas_datapath.sv]
// Datapath: table memories, grid scan, serial divider, row blend and compare.
module icas_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  icas_pkg::in_item_t in_item,
  input  logic               load_en,
  input  logic [5:0]         ne_cfg,
  input  logic [6:0]         na_cfg,
  input  icas_pkg::icas_cmd_t cmd,
  output icas_pkg::icas_sts_t sts,
  output icas_pkg::out_item_t res
);
  import icas_pkg::*;

  logic signed [23:0] grid_mem [MAX_ENERGIES];
  logic [15:0]        ang_mem  [MAX_ANGLES];
  logic [16:0]        cdf_mem  [MAX_ANGLES*MAX_ENERGIES];

  logic signed [23:0] x_r, g_rd_r, g_prev_r, gl_r, gr_r;
  logic [15:0]        rnd_r;
  logic [5:0]         ne_r;
  logic [6:0]         na_r;
  logic [5:0]         gi_r;      // grid read index, 0..ne-1
  logic [COL_W-1:0]   left_r, right_r;
  logic               found_r;
  logic [1:0]         clamp_r;
  logic               gdone_r;
  logic [24:0]        den_r;
  logic [24:0]        rem_r;
  logic [15:0]        q_r;
  logic [4:0]         dcnt_r;
  logic [6:0]         row_r;     // row being read, runs up to na + 2
  logic [16:0]        cl_r, cr_r;
  logic [15:0]        ang_r;
  logic               hit_r;
  logic [ROW_W-1:0]   pick_r;

  logic [5:0]  ne_sat;
  logic [6:0]  na_sat;
  logic        wr_grid, wr_ang, wr_cdf;

  always_comb begin
    ne_sat = (ne_cfg < 6'd2) ? 6'd2 : ((ne_cfg > 6'(MAX_ENERGIES)) ? 6'(MAX_ENERGIES) : ne_cfg);
    na_sat = (na_cfg < 7'd1) ? 7'd1 : ((na_cfg > 7'(MAX_ANGLES)) ? 7'(MAX_ANGLES) : na_cfg);
    wr_grid = load_en && in_item.req_type == REQ_GRID;
    wr_ang  = load_en && in_item.req_type == REQ_ANGLE;
    wr_cdf  = load_en && in_item.req_type == REQ_CDF;
  end

  always_ff @(posedge clk) begin
    if (wr_grid) grid_mem[in_item.column_index] <= in_item.grid_value;
    if (wr_ang) ang_mem[in_item.row_index] <=
      in_item.table_value[16] ? 16'hFFFF : in_item.table_value[15:0];
    if (wr_cdf) cdf_mem[{in_item.row_index, in_item.column_index}] <= in_item.table_value;
  end

  // registered table reads
  always_ff @(posedge clk) begin
    g_rd_r <= grid_mem[gi_r[COL_W-1:0]];
    cl_r   <= cdf_mem[{row_r[ROW_W-1:0], left_r}];
    cr_r   <= cdf_mem[{row_r[ROW_W-1:0], right_r}];
    if (cmd.fin) ang_r <= ang_mem[pick_r];
  end

  // grid scan: step k sees g_rd_r = g[k-1] (k>=1); compare pairs (g[k-2], g[k-1])
  logic [5:0]  k_r;
  logic signed [24:0] num_w;
  always_comb num_w = 25'(x_r) - 25'(gl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gdone_r <= 1'b0;
    end else if (cmd.capture) begin
      x_r     <= in_item.log_energy;
      rnd_r   <= in_item.random_fraction;
      ne_r    <= ne_sat;
      na_r    <= na_sat;
      gi_r    <= 6'd0;
      k_r     <= 6'd0;
      found_r <= 1'b0;
      left_r  <= '0;
      right_r <= '0;
      clamp_r <= CLAMP_NONE;
      gdone_r <= 1'b0;
    end else if (cmd.grid_step && !gdone_r) begin
      gi_r     <= (gi_r == ne_r - 6'd1) ? gi_r : gi_r + 6'd1;
      k_r      <= k_r + 6'd1;
      g_prev_r <= g_rd_r;
      if (k_r == 6'd1 && x_r <= g_rd_r) begin
        clamp_r <= CLAMP_BELOW;
        gdone_r <= 1'b1;
      end else if (k_r >= 6'd2) begin
        if (x_r >= g_prev_r && x_r < g_rd_r) begin
          found_r <= 1'b1;
          left_r  <= COL_W'(k_r - 6'd2);
          right_r <= COL_W'(k_r - 6'd1);
          gl_r    <= g_prev_r;
          gr_r    <= g_rd_r;
        end
        if (k_r == ne_r) begin
          gdone_r <= 1'b1;
          if (x_r >= g_rd_r) begin
            clamp_r <= CLAMP_ABOVE;
            found_r <= 1'b0;
            left_r  <= COL_W'(ne_r - 6'd1);
            right_r <= COL_W'(ne_r - 6'd1);
          end
        end
      end
    end
  end

  // restoring divider: num < den, so 16 steps give floor((num << 16) / den)
  logic [26:0] trial;
  always_comb trial = {1'b0, rem_r, 1'b0} - {2'b00, den_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      den_r  <= 25'(gr_r) - 25'(gl_r);
      rem_r  <= num_w;
      q_r    <= '0;
      dcnt_r <= 5'd16;
    end else if (cmd.div_step && dcnt_r != 5'd0) begin
      dcnt_r <= dcnt_r - 5'd1;
      if (!trial[26]) rem_r <= trial[24:0];
      else            rem_r <= {rem_r[23:0], 1'b0};
      q_r <= {q_r[14:0], !trial[26]};
    end
  end

  // blend: read row k, multiply in the next cycle, compare when row_r = k + 2
  logic [16:0] wgt;
  logic [16:0] wgt_inv;
  logic [33:0] p_l_r, p_r_r;
  logic [34:0] blend_sum;
  logic        cv_r, pv_r;
  always_comb begin
    wgt       = found_r ? {1'b0, q_r} : 17'd0;
    wgt_inv   = 17'h10000 - wgt;
    blend_sum = 35'(p_l_r) + 35'(p_r_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r  <= 1'b0;
      pv_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      cv_r <= cmd.row_eval && (row_r < na_r);
      pv_r <= cv_r;
      if (cmd.row_clear) begin
        row_r  <= '0;
        hit_r  <= 1'b0;
        pick_r <= ROW_W'(na_r - 7'd1);
      end
      if (cv_r) begin
        p_l_r <= cl_r * wgt_inv;
        p_r_r <= cr_r * wgt;
      end
      if (cmd.row_issue) row_r <= row_r + 7'd1;
      if (pv_r && !hit_r) begin
        if ({19'd0, rnd_r} <= (blend_sum >> 16)) begin
          hit_r  <= 1'b1;
          pick_r <= ROW_W'(row_r - 7'd2);
        end
      end
    end
  end

  always_comb begin
    sts.grid_done = gdone_r;
    sts.need_div  = found_r;
    sts.div_done  = (dcnt_r == 5'd0);
    sts.row_hit   = hit_r;
    sts.row_last  = (row_r == na_r + 7'd1);
    res.angle_code   = ang_r;
    res.chosen_row   = pick_r;
    res.energy_clamp = clamp_r;
    res.fell_through = !hit_r;
  end

endmodule

[rtl/icas_ctrl.sv]
// Controller: sequences grid scan, division, row scan and result strobe.
module icas_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          req_type,
  output logic                busy,
  output logic                load_en,
  output logic                out_valid,
  output icas_pkg::icas_cmd_t cmd,
  input  icas_pkg::icas_sts_t sts
);
  import icas_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GRID = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_ROWS = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    load_en   = 1'b0;
    out_valid = 1'b0;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_SAMPLE) begin
            cmd.capture = 1'b1;
            state_nxt   = S_GRID;
          end else begin
            load_en = 1'b1;
          end
        end
      end
      S_GRID: begin
        cmd.grid_step = 1'b1;
        if (sts.grid_done) begin
          cmd.grid_step = 1'b0;
          cmd.div_start = sts.need_div;
          state_nxt     = sts.need_div ? S_DIV : S_ROWS;
          cmd.row_clear = !sts.need_div;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.row_clear = 1'b1;
          state_nxt     = S_ROWS;
        end
      end
      S_ROWS: begin
        cmd.row_issue = 1'b1;
        cmd.row_eval  = 1'b1;
        if (sts.row_hit || sts.row_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load_en |-> !busy) else $error("load while busy");

endmodule

[rtl/interpolated_cdf_angle_sampler_top.sv]
// Top level of the interpolated CDF angle sampler.
//  channel | ports                       | transfer
//  input   | start, busy, in_item        | start & !busy
//  result  | out_valid, out_item         | out_valid, one cycle
//  config  | cfg_we, cfg_index, cfg_data | cfg_we
// A load is taken while idle and does not raise busy. A sample runs from one start to
// the next through: grid scan through one memory port, a 16-step serial divider,
// one blended row per cycle, then result and strobe. Below- and above-grid skip the divider.
// Reset sets energies_in_use to 32 and angles_in_use to 64; tables are undefined.
// The receiver cannot stall; a result is shown for one cycle.
module interpolated_cdf_angle_sampler_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  icas_pkg::in_item_t  in_item,
  output logic                out_valid,
  output icas_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data
);
  import icas_pkg::*;

  logic [5:0] ne_r;
  logic [6:0] na_r;
  logic       load_en;
  icas_cmd_t  cmd;
  icas_sts_t  sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r <= 6'd32;
      na_r <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ENERGIES)    ne_r <= cfg_data[5:0];
      else if (cfg_index == CFG_ANGLES) na_r <= cfg_data;
    end
  end

  icas_ctrl u_ctrl (
    .clk, .rst_n, .start, .req_type(in_item.req_type), .busy, .load_en,
    .out_valid, .cmd, .sts
  );

  icas_datapath u_dp (
    .clk, .rst_n, .in_item, .load_en, .ne_cfg(ne_r), .na_cfg(na_r),
    .cmd, .sts, .res(out_item)
  );

endmodule

[bench/tb_top.sv]
// Testbench for the interpolated CDF angle sampler: table loads, directed and random samples.
`timescale 1ns / 100ps

module tb_top;
  import icas_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_ENERGIES;
  logic [6:0] cfg_data = '0;

  interpolated_cdf_angle_sampler_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow state of the sampler
  longint      grid_sh [MAX_ENERGIES];
  logic [15:0] angle_sh [MAX_ANGLES];
  logic [16:0] cdf_sh [MAX_ANGLES][MAX_ENERGIES];
  logic [6:0]  energies_reg = 7'd32;
  logic [6:0]  angles_reg = 7'd64;

  out_item_t pending_samples [$];
  int fails = 0;
  int n_samples = 0, n_fell = 0, n_below = 0, n_above = 0, n_interp = 0;
  int idle_pct = 0;
  longint cycles = 0;

  function automatic in_item_t mk(logic [1:0] t, int row, int col, int gv, int tv,
                                  int le, int rnd);
    in_item_t it;
    it = '0;
    it.req_type = t;
    it.row_index = row[5:0];
    it.column_index = col[4:0];
    it.grid_value = gv[23:0];
    it.table_value = tv[16:0];
    it.log_energy = le[23:0];
    it.random_fraction = rnd[15:0];
    return it;
  endfunction

  function automatic out_item_t pick_angle(in_item_t it);
    longint x, num, den, w, bl;
    int ne, na, lcol, rcol, i;
    logic [1:0] cl;
    bit found;
    out_item_t o;
    ne = energies_reg[5:0];
    na = angles_reg;
    if (ne < 2) ne = 2;
    if (ne > MAX_ENERGIES) ne = MAX_ENERGIES;
    if (na < 1) na = 1;
    if (na > MAX_ANGLES) na = MAX_ANGLES;
    x = it.log_energy;
    lcol = 0; rcol = 0; w = 0; cl = CLAMP_NONE; found = 0;
    if (x <= grid_sh[0]) begin
      cl = CLAMP_BELOW;
    end else if (x >= grid_sh[ne-1]) begin
      cl = CLAMP_ABOVE;
      lcol = ne - 1; rcol = ne - 1;
    end else begin
      for (i = 0; i + 1 < ne; i++)
        if (x >= grid_sh[i] && x < grid_sh[i+1]) begin
          lcol = i; rcol = i + 1; found = 1;
        end
      if (found) begin
        num = x - grid_sh[lcol];
        den = grid_sh[rcol] - grid_sh[lcol];
        w = (num <<< 16) / den;
        if (w > 65535) w = 65535;
      end
    end
    o.chosen_row = 6'(na - 1);
    o.fell_through = 1'b1;
    for (i = 0; i < na; i++) begin
      bl = (longint'(cdf_sh[i][lcol]) * (65536 - w) + longint'(cdf_sh[i][rcol]) * w) >>> 16;
      if (longint'(it.random_fraction) <= bl) begin
        o.chosen_row = 6'(i);
        o.fell_through = 1'b0;
        break;
      end
    end
    o.angle_code = angle_sh[o.chosen_row];
    o.energy_clamp = cl;
    return o;
  endfunction

  // update shadow state for an accepted transfer; queue the prediction, or the given result, for samples
  task automatic absorb(in_item_t it, bit typed, out_item_t typed_res);
    case (it.req_type)
      REQ_GRID:  grid_sh[it.column_index] = it.grid_value;
      REQ_ANGLE: angle_sh[it.row_index] = (it.table_value > 17'd65535) ? 16'hFFFF
                                          : it.table_value[15:0];
      REQ_CDF:   cdf_sh[it.row_index][it.column_index] = it.table_value;
      default: begin
        pending_samples = {pending_samples, (typed ? typed_res : pick_angle(it))};
        n_samples++;
      end
    endcase
  endtask

  task automatic send(in_item_t it, bit typed = 0, out_item_t typed_res = '0);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    absorb(it, typed, typed_res);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0 || busy) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_regs(int ne, int na);
    cfg_we <= 1'b1; cfg_index <= CFG_ENERGIES; cfg_data <= ne[6:0];
    @(posedge clk);
    energies_reg = {1'b0, ne[5:0]};
    cfg_index <= CFG_ANGLES; cfg_data <= na[6:0];
    @(posedge clk);
    angles_reg = na[6:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_sorted_grid();
    int v;
    v = -$urandom_range(4000000);
    for (int c = 0; c < MAX_ENERGIES; c++) begin
      send(mk(REQ_GRID, $urandom_range(63), c, v, $urandom_range(131071), 0, 0));
      v += ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 250000);
    end
  endtask

  task automatic random_item();
    int k, row, col, lo, hi, le, tv;
    k = $urandom_range(99);
    row = $urandom_range(63);
    col = $urandom_range(31);
    if (k < 3) begin
      load_sorted_grid();
    end else if (k < 6) begin
      send(mk(REQ_GRID, row, col, $urandom, $urandom, $urandom, $urandom));
    end else if (k < 14) begin
      send(mk(REQ_ANGLE, row, col, $urandom, $urandom_range(131071), $urandom, $urandom));
    end else if (k < 30) begin
      if ($urandom_range(9) == 0) begin
        send(mk(REQ_CDF, row, col, $urandom, $urandom_range(131071), $urandom, $urandom));
      end else begin
        tv = (row + 1) * 1024 - int'($urandom_range(1500));
        if (tv < 0) tv = 0;
        send(mk(REQ_CDF, row, col, $urandom, tv, $urandom, $urandom));
      end
    end else begin
      lo = int'(grid_sh[0]) - 20000;
      hi = int'(grid_sh[MAX_ENERGIES-1]) + 20000;
      if ($urandom_range(9) < 7 && lo < hi)
        le = lo + int'($urandom_range(hi - lo));
      else
        le = $urandom;
      if (le > 8388607) le = 8388607;
      if (le < -8388608) le = -8388608;
      send(mk(REQ_SAMPLE, row, col, $urandom, $urandom, le, $urandom_range(65535)));
    end
  endtask

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  stim_row_t dir_rows [17];

  initial begin
    dir_rows[0]  = '{mk(REQ_SAMPLE, 0, 0, 0, 0, -8388608, 0), 1, '{16'd1, 6'd0, CLAMP_BELOW, 1'b0}};
    dir_rows[1]  = '{mk(REQ_SAMPLE, 63, 31, -1, 131071, 8388607, 65535), 1,
                     '{16'd6301, 6'd63, CLAMP_ABOVE, 1'b0}};
    dir_rows[2]  = '{mk(REQ_SAMPLE, 0, 0, 0, 0, 'h18000, 5000), 0, '0};
    dir_rows[3]  = '{mk(REQ_ANGLE, 5, 0, 0, 65537, 0, 0), 0, '0};
    dir_rows[4]  = '{mk(REQ_SAMPLE, 0, 0, 0, 0, 5 << 16, 6000), 0, '0};
    dir_rows[5]  = '{mk(REQ_CDF, 63, 0, 0, 100, 0, 0), 0, '0};
    dir_rows[6]  = '{mk(REQ_SAMPLE, 0, 0, 0, 0, -8388608, 65535), 1,
                     '{16'd6301, 6'd63, CLAMP_BELOW, 1'b1}};
    dir_rows[7]  = '{mk(REQ_GRID, 0, 0, -8388608, 0, 0, 0), 0, '0};
    dir_rows[8]  = '{mk(REQ_GRID, 0, 31, 8388607, 0, 0, 0), 0, '0};
    dir_rows[9]  = '{mk(REQ_SAMPLE, 0, 0, 0, 0, 0, 33000), 0, '0};
    dir_rows[10] = '{mk(REQ_GRID, 0, 2, 1 << 16, 0, 0, 0), 0, '0};
    dir_rows[11] = '{mk(REQ_SAMPLE, 0, 0, 0, 0, 'h10000, 20000), 0, '0};
    dir_rows[12] = '{mk(REQ_SAMPLE, 0, 0, 0, 0, 'h18000, 40000), 0, '0};
    dir_rows[13] = '{mk(REQ_GRID, 0, 2, 0, 0, 0, 0), 0, '0};
    dir_rows[14] = '{mk(REQ_SAMPLE, 0, 0, 0, 0, 'h8000, 1), 0, '0};
    dir_rows[15] = '{mk(REQ_CDF, 0, 31, 0, 65536, 0, 0), 0, '0};
    dir_rows[16] = '{mk(REQ_SAMPLE, 0, 0, 0, 0, 8388607, 65535), 0, '0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every table entry so no sample reads an unwritten one
    for (int c = 0; c < MAX_ENERGIES; c++) send(mk(REQ_GRID, 0, c, c << 16, 0, 0, 0));
    for (int r = 0; r < MAX_ANGLES; r++) send(mk(REQ_ANGLE, r, 0, 0, r * 100 + 1, 0, 0));
    for (int r = 0; r < MAX_ANGLES; r++)
      for (int c = 0; c < MAX_ENERGIES; c++)
        send(mk(REQ_CDF, r, c, 0, (r + 1) * 1024, 0, 0));

    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    drain();
    load_sorted_grid();

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin set_regs(32, 64); idle_pct = 0;  end
        1: begin set_regs(2, 1);   idle_pct = 50; end
        2: begin set_regs(0, 0);   idle_pct = 0;  end
        3: begin set_regs(127, 127); idle_pct = 32; end
        4: begin set_regs(17, 40); idle_pct = 50; end
        default: begin set_regs(5, 64); idle_pct = 32; end
      endcase
      for (int n = 0; n < 135; n++) begin
        if (ph == 1 && n == 60) drain();
        random_item();
      end
    end

    drain();
    $display("Run: %0d samples (%0d interpolated, %0d below, %0d above, %0d fell through)",
             n_samples, n_interp, n_below, n_above, n_fell);
    $display("over six register settings including both extremes and idle mixes");
    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        fails++;
      end else begin
        e = pending_samples.pop_front();
        if (e.angle_code !== out_item.angle_code) begin
          $display("%0t: angle_code exp %h got %h", $time, e.angle_code, out_item.angle_code);
          fails++;
        end
        if (e.chosen_row !== out_item.chosen_row) begin
          $display("%0t: chosen_row exp %0d got %0d", $time, e.chosen_row, out_item.chosen_row);
          fails++;
        end
        if (e.energy_clamp !== out_item.energy_clamp) begin
          $display("%0t: energy_clamp exp %0d got %0d", $time, e.energy_clamp,
                   out_item.energy_clamp);
          fails++;
        end
        if (e.fell_through !== out_item.fell_through) begin
          $display("%0t: fell_through exp %b got %b", $time, e.fell_through,
                   out_item.fell_through);
          fails++;
        end
        n_fell += e.fell_through;
        case (e.energy_clamp)
          CLAMP_BELOW: n_below++;
          CLAMP_ABOVE: n_above++;
          default: n_interp++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("timeout at %0t", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
